// ===== design/pcev_pkg.sv =====
// shared types and constants of the pixel change validator
package pcev_pkg;

    localparam int unsigned AlphaW  = 16;
    localparam int unsigned ThreshW = 17;
    localparam int unsigned FrameW  = 20;
    localparam int unsigned PixW    = 8;
    localparam int unsigned CfgW    = 20;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_EMA_WEIGHT  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DIST_WEIGHT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OVERLAY     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_FRAME_PIX   = 3'd4;

    localparam logic [PixW-1:0] FULL_RED    = 8'hff;
    localparam int unsigned     NOISE_LEVEL = 10;

    typedef struct packed {
        logic [PixW-1:0] pix_red;
        logic [PixW-1:0] pix_green;
        logic [PixW-1:0] pix_blue;
        logic            fire_candidate;
    } pixel_t;

    typedef struct packed {
        logic            change_flag;
        logic            paint_valid;
        logic [PixW-1:0] overlay_red;
        logic [PixW-1:0] overlay_green;
        logic [PixW-1:0] overlay_blue;
        logic            end_of_frame;
    } result_t;

    typedef struct packed {
        logic [AlphaW-1:0]  ema_weight;
        logic [AlphaW-1:0]  distance_weight;
        logic [ThreshW-1:0] change_threshold;
        logic               overlay_enable;
        logic [FrameW-1:0]  frame_pixels;
    } cfg_t;

endpackage

// ===== design/pcev_if.sv =====
// valid/ready channel interfaces for pixels and results
interface pcev_pix_if;
    logic            valid;
    logic            ready;
    pcev_pkg::pixel_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcev_res_if;
    logic             valid;
    logic             ready;
    pcev_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pcev_ram.sv =====
// generic single port write, single port read ram with registered read
module pcev_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== design/pcev_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module pcev_isqrt #(
    parameter int unsigned IN_W = 36
) (
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     radicand,
    output logic [IN_W/2-1:0]   root
);
    localparam int unsigned OUT_W = IN_W / 2;

    // stage s holds remainder and partial root once bit OUT_W-1-s is decided
    logic [IN_W-1:0]  rem_reg   [OUT_W];
    logic [OUT_W-1:0] root_reg  [OUT_W];
    logic [IN_W-1:0]  rem_next  [OUT_W];
    logic [OUT_W-1:0] root_next [OUT_W];

    always_comb
    begin
        logic [IN_W-1:0]  rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  sq;
        logic [IN_W:0]    diff;
        rem_in  = radicand;
        root_in = '0;
        for (int s = 0; s < OUT_W; s++)
        begin
            // (r+2^b)^2 - r^2 = 2^(2b) + r*2^(b+1), r has zeros below b
            sq   = (IN_W'(root_in) << (OUT_W - s)) | (IN_W'(1) << (2 * (OUT_W - 1 - s)));
            diff = {1'b0, rem_in} - {1'b0, sq};
            if (!diff[IN_W])
            begin
                rem_next[s]  = diff[IN_W-1:0];
                root_next[s] = root_in | (OUT_W'(1) << (OUT_W - 1 - s));
            end
            else
            begin
                rem_next[s]  = rem_in;
                root_next[s] = root_in;
            end
            rem_in  = rem_reg[s];
            root_in = root_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < OUT_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root = root_reg[OUT_W-1];
endmodule

// ===== design/pixel_color_ema_change_validator.sv =====
// top level: per-pixel colour ema and distance average change detector
//
// pixels enter on pix_in (valid/ready), one request per pixel in raster
// order; results leave on res_out, one request per pixel, in order.
// configuration goes through cfg_we/cfg_idx/cfg_data while the block is idle.
// the averages live in two synchronous rams addressed by pixel position.
// a pixel flows through FRAC_BITS + 15 stages (23 by default): ram read,
// colour blend, differences, squares, sum, square root (FRAC_BITS + 9
// stages, one bit each), distance blend and flag; the output register
// follows and holds the result. the ema is written back in the blend
// stage and the distance average in the last stage. for frames no longer
// than the pipeline the input is held off while an older request on the
// same position is still in flight; otherwise one pixel per clock.
// the whole pipeline advances only when the output register is empty or
// taken, so a receiver stall freezes every stage and pix_in.ready follows
// res_out.ready combinationally.
// reset clears position, the loaded flag and the pipeline valids, and
// restores the configuration defaults; ram contents are undefined and
// the first frame loads them, giving flag 0 for every pixel of that frame.
module pixel_color_ema_change_validator #(
    parameter int unsigned MAX_PIXELS = 524288,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pcev_pix_if.sink                      pix_in,
    pcev_res_if.source                    res_out,
    input  logic                          cfg_we,
    input  logic [pcev_pkg::CfgIdxW-1:0]  cfg_idx,
    input  logic [pcev_pkg::CfgW-1:0]     cfg_data
);
    localparam int unsigned AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned CW   = $clog2(MAX_PIXELS + 1);
    localparam int unsigned PW   = pcev_pkg::PixW;
    localparam int unsigned EW   = PW + FRAC_BITS;          // ema per channel
    localparam int unsigned DW   = 9 + FRAC_BITS;           // distance average
    localparam int unsigned SQW  = 2 * EW + 2;              // sum of squares
    localparam int unsigned SQIN = SQW + (SQW % 2);
    localparam int unsigned RW   = SQIN / 2;
    localparam int unsigned NS   = RW;                      // sqrt stages
    localparam int unsigned LAT  = 4 + NS + 2;              // stages holding items
    localparam int unsigned QW   = pcev_pkg::AlphaW;
    localparam logic [DW-1:0] DMA_MAX = '1;

    // ------------------------------------------------------------ config
    pcev_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ema_weight       <= 16'd16384;
            cfg_reg.distance_weight  <= 16'd49152;
            cfg_reg.change_threshold <= 17'd3072;
            cfg_reg.overlay_enable   <= 1'b0;
            cfg_reg.frame_pixels     <= 20'd307200;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                pcev_pkg::REG_EMA_WEIGHT:  cfg_reg.ema_weight <= cfg_data[QW-1:0];
                pcev_pkg::REG_DIST_WEIGHT: cfg_reg.distance_weight <= cfg_data[QW-1:0];
                pcev_pkg::REG_THRESHOLD:
                    cfg_reg.change_threshold <= cfg_data[pcev_pkg::ThreshW-1:0];
                pcev_pkg::REG_OVERLAY:     cfg_reg.overlay_enable <= cfg_data[0];
                pcev_pkg::REG_FRAME_PIX:   cfg_reg.frame_pixels <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame length, clamped to 1..MAX_PIXELS
    logic [CW-1:0] frame_len;
    always_comb
    begin
        if (cfg_reg.frame_pixels == '0)
            frame_len = CW'(1);
        else if (32'(cfg_reg.frame_pixels) > MAX_PIXELS)
            frame_len = CW'(MAX_PIXELS);
        else
            frame_len = CW'(cfg_reg.frame_pixels);
    end

    // ------------------------------------------------------------ pipeline control
    logic advance;
    logic out_valid_reg;
    assign advance = !out_valid_reg || res_out.ready;

    // per-stage item state
    logic [LAT-1:0] vld_reg;
    logic [AW-1:0]  addr_reg   [LAT];
    logic           load_reg   [LAT];
    logic           cand_reg   [LAT];
    logic           eof_reg    [LAT];
    logic [PW-1:0]  green_reg  [LAT];
    logic [PW-1:0]  blue_reg   [LAT];
    logic [PW-1:0]  red_reg    [2];

    // hazard: same address still in flight before its dma is written back
    logic hazard;
    logic [AW-1:0] pos_reg;
    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < LAT; i++)
        begin
            if (vld_reg[i] && addr_reg[i] == pos_reg)
                hazard = 1'b1;
        end
    end

    logic accept;
    assign pix_in.ready = advance && !hazard;
    assign accept       = pix_in.valid && pix_in.ready;

    logic primed_reg;
    logic eof_in;
    assign eof_in = (CW'(pos_reg) + CW'(1) >= frame_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (eof_in)
            begin
                pos_reg    <= '0;
                primed_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= pos_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            addr_reg[0]  <= pos_reg;
            load_reg[0]  <= !primed_reg;
            cand_reg[0]  <= pix_in.data.fire_candidate;
            eof_reg[0]   <= eof_in;
            green_reg[0] <= pix_in.data.pix_green;
            blue_reg[0]  <= pix_in.data.pix_blue;
            red_reg[0]   <= pix_in.data.pix_red;
            for (int i = 1; i < LAT; i++)
            begin
                addr_reg[i]  <= addr_reg[i-1];
                load_reg[i]  <= load_reg[i-1];
                cand_reg[i]  <= cand_reg[i-1];
                eof_reg[i]   <= eof_reg[i-1];
                green_reg[i] <= green_reg[i-1];
                blue_reg[i]  <= blue_reg[i-1];
            end
            red_reg[1] <= red_reg[0];
        end
    end

    // ------------------------------------------------------------ memories
    logic [3*EW-1:0] ema_rd, ema_wr;
    logic [DW-1:0]   dma_rd, dma_wr;
    logic            ema_we, dma_we;
    logic [DW-1:0]   dma_hold_reg [1:LAT-1];

    pcev_ram #(.WIDTH(3*EW), .DEPTH(MAX_PIXELS)) u_ema_ram (
        .clk     (clk),
        .wr_en   (ema_we),
        .wr_addr (addr_reg[1]),
        .wr_data (ema_wr),
        .rd_en   (advance),
        .rd_addr (pos_reg),
        .rd_data (ema_rd)
    );

    pcev_ram #(.WIDTH(DW), .DEPTH(MAX_PIXELS)) u_dma_ram (
        .clk     (clk),
        .wr_en   (dma_we),
        .wr_addr (addr_reg[LAT-1]),
        .wr_data (dma_wr),
        .rd_en   (advance),
        .rd_addr (pos_reg),
        .rd_data (dma_rd)
    );

    // stage 1: colour blend products (one multiplier per term)
    logic [EW+QW-1:0] prod_old_reg [3];
    logic [EW+QW-1:0] prod_new_reg [3];
    logic [EW-1:0]    pixq [3];
    logic [EW-1:0]    emaq [3];
    logic [QW:0]      one_minus_a1;

    assign one_minus_a1 = (QW+1)'(1 << QW) - (QW+1)'(cfg_reg.ema_weight);

    always_comb
    begin
        pixq[0] = {red_reg[0],   FRAC_BITS'(0)};
        pixq[1] = {green_reg[0], FRAC_BITS'(0)};
        pixq[2] = {blue_reg[0],  FRAC_BITS'(0)};
        for (int k = 0; k < 3; k++)
            emaq[k] = ema_rd[(2-k)*EW +: EW];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_old_reg[k] <= (EW+QW)'(emaq[k] * one_minus_a1);
                prod_new_reg[k] <= (EW+QW)'(pixq[k] * cfg_reg.ema_weight);
            end
            // stored distance average travels with its pixel
            dma_hold_reg[1] <= dma_rd;
            for (int i = 2; i < LAT; i++)
                dma_hold_reg[i] <= dma_hold_reg[i-1];
        end
    end

    // stage 2: new ema, write back, differences
    logic [EW+QW:0]  ema_sum [3];
    logic [EW-1:0]   ema_new [3];
    logic [EW-1:0]   pix1q   [3];
    logic [EW-1:0]   diff_reg [3];

    always_comb
    begin
        pix1q[0] = {red_reg[1],   FRAC_BITS'(0)};
        pix1q[1] = {green_reg[1], FRAC_BITS'(0)};
        pix1q[2] = {blue_reg[1],  FRAC_BITS'(0)};
        for (int k = 0; k < 3; k++)
        begin
            ema_sum[k] = (EW+QW+1)'(prod_old_reg[k]) + (EW+QW+1)'(prod_new_reg[k]);
            ema_new[k] = load_reg[1] ? pix1q[k] : EW'(ema_sum[k] >> QW);
        end
        ema_wr = {ema_new[0], ema_new[1], ema_new[2]};
        ema_we = advance && vld_reg[1] && (load_reg[1] || cand_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
                diff_reg[k] <= (pix1q[k] >= ema_new[k]) ? pix1q[k] - ema_new[k]
                                                        : ema_new[k] - pix1q[k];
        end
    end

    // stage 3: squares, stage 4: sum
    logic [2*EW-1:0] sq_reg [3];
    logic [SQIN-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
                sq_reg[k] <= diff_reg[k] * diff_reg[k];
            sum_reg <= SQIN'(sq_reg[0]) + SQIN'(sq_reg[1]) + SQIN'(sq_reg[2]);
        end
    end

    // stages 5 .. 4+NS: square root
    logic [RW-1:0] root;
    pcev_isqrt #(.IN_W(SQIN)) u_isqrt (
        .clk      (clk),
        .en       (advance),
        .radicand (sum_reg),
        .root     (root)
    );

    // next stage: distance blend products
    localparam int unsigned TW = (RW > DW) ? RW : DW;
    logic [TW-1:0]      target;
    logic [QW:0]        one_minus_a2;
    logic [TW+QW:0]     dprod_old_reg, dprod_new_reg;

    assign one_minus_a2 = (QW+1)'(1 << QW) - (QW+1)'(cfg_reg.distance_weight);
    assign target = cand_reg[LAT-2] ? TW'(root)
                                    : TW'(pcev_pkg::NOISE_LEVEL << FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dprod_old_reg <= (TW+QW+1)'(dma_hold_reg[LAT-2] * one_minus_a2);
            dprod_new_reg <= (TW+QW+1)'(target * cfg_reg.distance_weight);
        end
    end

    // last internal stage: sum, saturate, write back, compare
    logic [TW+QW+1:0] dsum;
    logic [TW:0]      dshift;
    logic             flag;
    always_comb
    begin
        dsum   = (TW+QW+2)'(dprod_old_reg) + (TW+QW+2)'(dprod_new_reg);
        dshift = (TW+1)'(dsum >> QW);
        if (load_reg[LAT-1])
            dma_wr = '0;
        else if (dshift > (TW+1)'(DMA_MAX))
            dma_wr = DMA_MAX;
        else
            dma_wr = DW'(dshift);
        dma_we = advance && vld_reg[LAT-1];
        flag = !load_reg[LAT-1] &&
               ({dma_wr, 8'd0} >= {cfg_reg.change_threshold, FRAC_BITS'(0)});
    end

    // ------------------------------------------------------------ output register
    pcev_pkg::result_t out_reg;
    logic paint;
    assign paint = flag && cfg_reg.overlay_enable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.change_flag   <= flag;
            out_reg.paint_valid   <= paint;
            out_reg.overlay_red   <= paint ? pcev_pkg::FULL_RED : '0;
            out_reg.overlay_green <= paint ? green_reg[LAT-1] : '0;
            out_reg.overlay_blue  <= paint ? blue_reg[LAT-1] : '0;
            out_reg.end_of_frame  <= eof_reg[LAT-1];
        end
    end

    assign res_out.valid = out_valid_reg;
    assign res_out.data  = out_reg;
endmodule

// ===== design/pcev_checker.sv =====
// port-level checks of the change validator, bound to the top level
module pcev_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input pcev_pkg::result_t res_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result dropped while stalled");

    a_paint: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.paint_valid |-> res_data.change_flag)
        else $error("paint without flag");

    a_red: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.overlay_red == pcev_pkg::FULL_RED) == res_data.paint_valid)
        else $error("overlay red mismatch");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.paint_valid |->
            res_data.overlay_green == '0 && res_data.overlay_blue == '0)
        else $error("overlay colour without paint");
endmodule

bind pixel_color_ema_change_validator pcev_checker u_pcev_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_out.valid),
    .res_ready (res_out.ready),
    .res_data  (res_out.data)
);
